[rtl/core/thcpr_pkg.sv]
// Package for the two-hand clock page replacer: request codes, frame classes,
// entry layout and default parameters. No dependencies.
`timescale 1ns / 1ps
package thcpr_pkg;
  localparam int unsigned FramesDef    = 4096;
  localparam int unsigned ScanBatchDef = 64;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_REF  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_SEL  = 2'd3
  } req_e;

  localparam logic [1:0] ClsFree     = 2'd0;
  localparam logic [1:0] ClsReserved = 2'd1;
  localparam logic [1:0] ClsInUse    = 2'd2;

  localparam logic [1:0] AddrBase = 2'd0;
  localparam logic [1:0] AddrCrit = 2'd1;
  localparam logic [1:0] AddrLow  = 2'd2;

  // entry: {dirty, accessed, mapped, class[1:0]}
  typedef struct packed {
    logic       dirty;
    logic       accessed;
    logic       mapped;
    logic [1:0] cls;
  } entry_t;

  typedef struct packed {
    req_e       req;
    logic [11:0] frame;
    logic [1:0] cls;
    logic       mapped;
    logic       is_write;
    logic       in_range;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_WB,
    ST_TICK_RD,
    ST_TICK_WB,
    ST_SEL_RD,
    ST_SEL_EX,
    ST_FB_RD,
    ST_FB_EX,
    ST_DONE
  } state_e;
endpackage

[rtl/core/thcpr_front.sv]
// Front part: accepts words, normalises the class code, flags range, and
// holds them in a two-entry queue. Depends on thcpr_pkg.
`timescale 1ns / 1ps
module thcpr_front #(
  parameter int unsigned FRAMES = thcpr_pkg::FramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        req_type_i,
  input  logic [11:0]       frame_i,
  input  logic [1:0]        frame_class_i,
  input  logic              mapped_i,
  input  logic              is_write_i,
  output logic              cmd_valid_o,
  output thcpr_pkg::cmd_t   cmd_o,
  input  logic              cmd_pop_i
);
  thcpr_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rp_q, wp_q;
  logic       push;
  thcpr_pkg::cmd_t c;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_comb begin
    c.req      = thcpr_pkg::req_e'(req_type_i);
    c.frame    = frame_i;
    c.cls      = (frame_class_i == 2'd3) ? thcpr_pkg::ClsReserved : frame_class_i;
    c.mapped   = mapped_i;
    c.is_write = is_write_i;
    c.in_range = ({20'd0, frame_i} < 32'(FRAMES));
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rp_q  <= 1'b0;
      wp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop of empty queue");
endmodule

[rtl/core/thcpr_back.sv]
// Back part: frame table memory, clearing pass, both hands, free count and
// result formation. Depends on thcpr_pkg.
`timescale 1ns / 1ps
module thcpr_back #(
  parameter int unsigned FRAMES     = thcpr_pkg::FramesDef,
  parameter int unsigned SCAN_BATCH = thcpr_pkg::ScanBatchDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  thcpr_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  input  logic [31:0]       region_base_i,
  input  logic [12:0]       crit_thr_i,
  input  logic [12:0]       low_thr_i,
  output logic              done_o,
  output logic              victim_found_o,
  output logic [11:0]       victim_frame_o,
  output logic [31:0]       victim_address_o,
  output logic              victim_dirty_o,
  output logic [12:0]       free_pages_o,
  output logic [1:0]        pressure_o
);
  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned SW = $clog2(2 * FRAMES + 1);
  localparam int unsigned BW = $clog2(SCAN_BATCH + 1);
  localparam int unsigned CW = $clog2(FRAMES + 1);

  thcpr_pkg::entry_t mem [FRAMES];
  thcpr_pkg::entry_t rd_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  thcpr_pkg::entry_t wdata;

  thcpr_pkg::state_e st_q, st_d;
  thcpr_pkg::cmd_t   cur_q, cur_d;
  logic [AW-1:0] sh_q, sh_d, vh_q, vh_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [SW-1:0] scn_q, scn_d;
  logic [1:0]    pass_q, pass_d;
  logic [BW-1:0] bc_q, bc_d;
  logic          fnd_q, fnd_d, vd_q, vd_d;
  logic [AW-1:0] vf_q, vf_d;
  logic [31:0]   vfx;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] f);
    nxt = ({1'b0, f} + 1'b1 >= (AW+1)'(FRAMES)) ? '0 : f + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= thcpr_pkg::ST_CLEAR;
      sh_q <= '0; vh_q <= '0; fc_q <= CW'(FRAMES); clr_q <= '0;
      scn_q <= '0; pass_q <= '0; bc_q <= '0; fnd_q <= 1'b0;
    end else begin
      st_q <= st_d; sh_q <= sh_d; vh_q <= vh_d; fc_q <= fc_d; clr_q <= clr_d;
      scn_q <= scn_d; pass_q <= pass_d; bc_q <= bc_d; fnd_q <= fnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; vf_q <= vf_d; vd_q <= vd_d;
  end

  always_comb begin
    thcpr_pkg::entry_t e;
    logic inuse;
    st_d = st_q; cur_d = cur_q; sh_d = sh_q; vh_d = vh_q; fc_d = fc_q;
    clr_d = clr_q; scn_d = scn_q; pass_d = pass_q; bc_d = bc_q;
    fnd_d = fnd_q; vf_d = vf_q; vd_d = vd_q;
    raddr = cur_q.frame[AW-1:0]; waddr = cur_q.frame[AW-1:0];
    we = 1'b0; wdata = rd_q; cmd_pop_o = 1'b0; done_o = 1'b0;
    e = rd_q;
    inuse = (rd_q.cls == thcpr_pkg::ClsInUse);
    case (st_q)
      thcpr_pkg::ST_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = '0;
        clr_d = clr_q + 1'b1;
        if ({1'b0, clr_q} == (AW+1)'(FRAMES - 1)) st_d = thcpr_pkg::ST_IDLE;
      end
      thcpr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1; cur_d = cmd_i; fnd_d = 1'b0; vf_d = '0; vd_d = 1'b0;
          case (cmd_i.req)
            thcpr_pkg::REQ_SET, thcpr_pkg::REQ_REF:
              st_d = cmd_i.in_range ? thcpr_pkg::ST_RD : thcpr_pkg::ST_DONE;
            thcpr_pkg::REQ_TICK: begin
              st_d = thcpr_pkg::ST_TICK_RD; bc_d = '0;
            end
            default: begin
              st_d = thcpr_pkg::ST_SEL_RD; scn_d = '0; pass_d = '0;
            end
          endcase
        end
      end
      thcpr_pkg::ST_RD: st_d = thcpr_pkg::ST_WB;
      thcpr_pkg::ST_WB: begin
        if (cur_q.req == thcpr_pkg::REQ_SET) begin
          we = 1'b1;
          fc_d = fc_q - CW'(rd_q.cls == thcpr_pkg::ClsFree)
                      + CW'(cur_q.cls == thcpr_pkg::ClsFree);
          e.cls = cur_q.cls; e.mapped = cur_q.mapped;
          if (!cur_q.mapped) begin e.accessed = 1'b0; e.dirty = 1'b0; end
        end else begin
          we = rd_q.mapped; e.accessed = 1'b1;
          if (cur_q.is_write) e.dirty = 1'b1;
        end
        wdata = e; st_d = thcpr_pkg::ST_DONE;
      end
      thcpr_pkg::ST_TICK_RD: begin
        raddr = sh_q; st_d = thcpr_pkg::ST_TICK_WB;
      end
      thcpr_pkg::ST_TICK_WB: begin
        waddr = sh_q; e.accessed = 1'b0; wdata = e;
        we = inuse && rd_q.mapped;
        sh_d = nxt(sh_q); bc_d = bc_q + 1'b1;
        st_d = (bc_q == BW'(SCAN_BATCH - 1)) ? thcpr_pkg::ST_DONE : thcpr_pkg::ST_TICK_RD;
      end
      thcpr_pkg::ST_SEL_RD: begin
        raddr = vh_q; st_d = thcpr_pkg::ST_SEL_EX;
      end
      thcpr_pkg::ST_SEL_EX: begin
        waddr = vh_q; vh_d = nxt(vh_q);
        st_d = thcpr_pkg::ST_SEL_RD;
        if (inuse && rd_q.mapped &&
            ((pass_q == 2'd0 && !rd_q.accessed && !rd_q.dirty) ||
             (pass_q == 2'd1 && !rd_q.accessed))) begin
          fnd_d = 1'b1; vf_d = vh_q; vd_d = rd_q.dirty; st_d = thcpr_pkg::ST_DONE;
        end else begin
          if (inuse && rd_q.mapped) begin
            we = rd_q.accessed; e.accessed = 1'b0; wdata = e;
            if (scn_q + 1'b1 >= SW'(FRAMES) && pass_q < 2'd2) begin
              pass_d = pass_q + 1'b1; scn_d = '0;
            end else scn_d = scn_q + 1'b1;
          end else scn_d = scn_q + 1'b1;
          if (scn_d == SW'(2 * FRAMES)) st_d = thcpr_pkg::ST_FB_RD;
        end
      end
      thcpr_pkg::ST_FB_RD: begin
        raddr = vh_q; st_d = thcpr_pkg::ST_FB_EX;
      end
      thcpr_pkg::ST_FB_EX: begin
        if (inuse) begin
          fnd_d = 1'b1; vf_d = vh_q; vd_d = rd_q.dirty; vh_d = nxt(vh_q);
        end
        st_d = thcpr_pkg::ST_DONE;
      end
      thcpr_pkg::ST_DONE: begin
        done_o = 1'b1; st_d = thcpr_pkg::ST_IDLE;
      end
      default: st_d = thcpr_pkg::ST_IDLE;
    endcase
  end

  assign vfx              = 32'(vf_q);
  assign victim_found_o   = fnd_q;
  assign victim_frame_o   = fnd_q ? 12'(vfx) : 12'd0;
  assign victim_address_o = fnd_q ? region_base_i + (vfx << 12) : 32'd0;
  assign victim_dirty_o   = fnd_q & vd_q;
  assign free_pages_o     = 13'(fc_q);
  assign pressure_o = (32'(fc_q) < 32'(crit_thr_i)) ? 2'd2 :
                      (32'(fc_q) < 32'(low_thr_i))  ? 2'd1 : 2'd0;

  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_q) <= FRAMES) else $error("free count out of range");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == thcpr_pkg::ST_IDLE) else $error("pop while busy");
endmodule

[rtl/core/two_hand_clock_page_replacer_top.sv]
// Top level of the two-hand clock page replacer: APB registers, front queue
// and back engine. Depends on thcpr_pkg, thcpr_front, thcpr_back.
//
// channel  | signals                                   | handshake
// command  | start_i, busy_o, req_type_i..is_write_i   | start_i && !busy_o
// result   | done_o, victim_*_o, free_pages_o, pressure_o | done_o, one cycle
// config   | psel..pwdata, prdata, pready              | psel&penable&pwrite
//
// Set-state and reference in range: read, write-back, done. Tick: read and
// write-back of SCAN_BATCH frames. Select: read and examine frames of the
// victim hand. After reset a clear pass zeroes all entries before any word.
// busy_o rises when the two-entry queue is full; results cannot be stalled.
`timescale 1ns / 1ps
module two_hand_clock_page_replacer_top #(
  parameter int unsigned FRAMES     = thcpr_pkg::FramesDef,
  parameter int unsigned SCAN_BATCH = thcpr_pkg::ScanBatchDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] frame_i,
  input  logic [1:0]  frame_class_i,
  input  logic        mapped_i,
  input  logic        is_write_i,
  output logic        done_o,
  output logic        victim_found_o,
  output logic [11:0] victim_frame_o,
  output logic [31:0] victim_address_o,
  output logic        victim_dirty_o,
  output logic [12:0] free_pages_o,
  output logic [1:0]  pressure_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] base_q;
  logic [12:0] crit_q, low_q;
  logic        wr;
  logic        cmd_valid, cmd_pop;
  thcpr_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'h0010_0000;
      crit_q <= 13'd32;
      low_q  <= 13'd128;
    end else if (wr) begin
      case (paddr[3:2])
        thcpr_pkg::AddrBase: base_q <= pwdata;
        thcpr_pkg::AddrCrit: crit_q <= pwdata[12:0];
        thcpr_pkg::AddrLow:  low_q  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      thcpr_pkg::AddrBase: prdata = base_q;
      thcpr_pkg::AddrCrit: prdata = {19'd0, crit_q};
      thcpr_pkg::AddrLow:  prdata = {19'd0, low_q};
      default:             prdata = 32'd0;
    endcase
  end

  thcpr_front #(.FRAMES(FRAMES)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .frame_i, .frame_class_i,
    .mapped_i, .is_write_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  thcpr_back #(.FRAMES(FRAMES), .SCAN_BATCH(SCAN_BATCH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .region_base_i(base_q), .crit_thr_i(crit_q), .low_thr_i(low_q), .done_o,
    .victim_found_o, .victim_frame_o, .victim_address_o, .victim_dirty_o,
    .free_pages_o, .pressure_o
  );
endmodule
